### rtl/tcf_pkg.sv
// ============================================================================
// tcf_pkg: shared types and constants of the traffic cell flux block
// Field widths, fixed-point formats, cell kinds and register indexes.
// ============================================================================
package tcf_pkg;

    localparam int LVL_W      = 20;              // Q12.8 level
    localparam int LANE_W     = 4;
    localparam int SPD_W      = 16;              // Q8.8 speed
    localparam int JAM_W      = 20;              // Q12.8 jam level per lane
    localparam int SHR_W      = 16;              // Q0.16 share
    localparam int REST_W     = SHR_W + 1;       // one minus share, up to 1.0
    localparam int CAP_W      = LANE_W + JAM_W;  // capacity level of a cell
    localparam int FLUX_W     = 32;              // Q24.8 flux on the ports
    localparam int Q_W        = 30;              // every internal flow fits here
    localparam int NUM_W      = CAP_W + Q_W;     // dividend width of the divider
    localparam int DIV_STEP   = 5;               // quotient bits per divider stage
    localparam int DIV_STAGES = Q_W / DIV_STEP;
    localparam int FLOW_LAT   = 3 + DIV_STAGES;  // latency of one flow lane
    localparam int QMAX_SHIFT = 10;              // qmax = speed * cap / 1024
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 20;

    localparam logic [SPD_W-1:0] FREE_SPEED_RST = 16'd8533;
    localparam logic [JAM_W-1:0] JAM_LEVEL_RST  = 20'd38400;
    localparam logic [SHR_W-1:0] SHARE_RST      = 16'd32768;
    localparam logic [LVL_W-1:0] BOUNDARY_RST   = 20'd0;

    typedef enum logic [1:0] {
        KIND_ENTRY    = 2'd0,
        KIND_EXIT     = 2'd1,
        KIND_DIVERGE  = 2'd2,
        KIND_ORDINARY = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREE_SPEED     = 2'd0,
        REG_JAM_LEVEL      = 2'd1,
        REG_DIVERGE_SHARE  = 2'd2,
        REG_BOUNDARY_LEVEL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        cell_kind;
        logic [LANE_W-1:0] lanes;
        logic [LVL_W-1:0]  own_level;
        logic [LVL_W-1:0]  next_level;
        logic [LANE_W-1:0] next_lanes;
        logic [LVL_W-1:0]  branch_level;
        logic [LANE_W-1:0] branch_lanes;
    } in_item_t;

    typedef struct packed {
        logic [FLUX_W-1:0] out_flux;
        logic [FLUX_W-1:0] self_inflow;
        logic              self_inflow_valid;
        logic [FLUX_W-1:0] next_inflow;
        logic              next_inflow_valid;
        logic [FLUX_W-1:0] branch_inflow;
        logic              branch_inflow_valid;
    } out_item_t;

endpackage

### rtl/tcf_in_if.sv
// ============================================================================
// tcf_in_if: input channel of the traffic cell flux block
// Valid/ready channel that carries one road cell per transaction.
// ============================================================================
interface tcf_in_if import tcf_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/tcf_out_if.sv
// ============================================================================
// tcf_out_if: output channel of the traffic cell flux block
// Valid/ready channel that carries one flux result per transaction.
// ============================================================================
interface tcf_out_if import tcf_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/traffic_cell_flux.sv
// ============================================================================
// traffic_cell_flux: Godunov outflow of one road cell
// Greenshields cell transmission flux for entry, exit, diverge and
// ordinary cells, with the inflows handed to the neighboring cells.
// ============================================================================
//
// Channel   Direction  Transaction carries
// --------  ---------  --------------------------------------------------
// item      in         one cell: kind, lanes, own level, two downstream cells
// result    out        outflow and the self, next and branch inflows
// wr_*      in         one configuration register write, no read-back
//
// One transaction enters per cycle while the output register is empty or
// being read. It then passes s0, s1, the flow lanes, g1, g2, the share
// dividers and g3, and result.valid rises when it reaches the output register.
// Reset clears the valid bits and loads the register defaults. A stall on
// the result side holds every stage at once, so item.ready falls in the
// same cycle and nothing is lost or repeated.
//
module traffic_cell_flux import tcf_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    tcf_in_if.sink               item,
    tcf_out_if.source            result
);

    // Side information that travels alongside the three flow lanes.
    typedef struct packed {
        kind_t          kind;
        logic           own_bc;
        logic           own_gt;
        logic           nxt_bc;
        logic           nxt_gt;
        logic           l3_bc;
        logic [Q_W-1:0] qmax_a;
        logic [Q_W-1:0] qmax_b;
        logic [Q_W-1:0] qmax_c;
    } sb_t;

    // Side information that travels alongside the share dividers.
    typedef struct packed {
        kind_t          kind;
        logic [Q_W-1:0] fx;
        logic [Q_W-1:0] self_in;
        logic           big1;
        logic           big2;
    } dsb_t;

    function automatic logic [LANE_W-1:0] lane_eff(input logic [LANE_W-1:0] n);
        return (n == '0) ? LANE_W'(1) : n;
    endfunction

    function automatic logic [Q_W-1:0] qmin(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [Q_W-1:0] qmax_of(input logic [SPD_W-1:0] s,
                                               input logic [CAP_W-1:0] c);
        logic [SPD_W+CAP_W-1:0] p;
        p = {{CAP_W{1'b0}}, s} * {{SPD_W{1'b0}}, c};
        return p[QMAX_SHIFT +: Q_W];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. The user writes only while the pipe is empty; unenforced.
    // ------------------------------------------------------------------
    logic [SPD_W-1:0] fs_reg;
    logic [JAM_W-1:0] jam_reg;
    logic [SHR_W-1:0] share_reg;
    logic [LVL_W-1:0] bnd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg    <= FREE_SPEED_RST;
            jam_reg   <= JAM_LEVEL_RST;
            share_reg <= SHARE_RST;
            bnd_reg   <= BOUNDARY_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                REG_FREE_SPEED:     fs_reg    <= wr_data[SPD_W-1:0];
                REG_JAM_LEVEL:      jam_reg   <= wr_data[JAM_W-1:0];
                REG_DIVERGE_SHARE:  share_reg <= wr_data[SHR_W-1:0];
                REG_BOUNDARY_LEVEL: bnd_reg   <= wr_data[LVL_W-1:0];
            endcase
        end
    end

    logic [JAM_W-1:0]  jam_eff;
    logic [REST_W-1:0] rest;

    // A jam level of zero behaves as one; the second branch gets one minus share.
    assign jam_eff = (jam_reg == '0) ? JAM_W'(1) : jam_reg;
    assign rest    = (REST_W'(1) << SHR_W) - REST_W'(share_reg);

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output register is free.
    // ------------------------------------------------------------------
    logic en;
    logic out_v_reg;

    assign en         = !out_v_reg || result.ready;
    assign item.ready = en;

    // Stage s0: the accepted transaction.
    in_item_t in_reg;
    logic     v0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= item.data;
    end

    // Stage s1: capacities and the level/capacity pair of each flow lane.
    // Lane A is always the own cell. For an entry cell lane B is the next
    // level and lane C the boundary level, both against the own capacity;
    // otherwise lanes B and C are the downstream cells with their own lanes.
    kind_t            kind0;
    logic [CAP_W-1:0] cap_own, cap_nxt, cap_br, bnd_lvl;

    assign kind0   = kind_t'(in_reg.cell_kind);
    assign cap_own = CAP_W'(lane_eff(in_reg.lanes)) * CAP_W'(jam_eff);
    assign cap_nxt = CAP_W'(lane_eff(in_reg.next_lanes)) * CAP_W'(jam_eff);
    assign cap_br  = CAP_W'(lane_eff(in_reg.branch_lanes)) * CAP_W'(jam_eff);
    assign bnd_lvl = CAP_W'(lane_eff(in_reg.lanes)) * CAP_W'(bnd_reg);

    kind_t            kind1_reg;
    logic [CAP_W-1:0] ra_reg, rb_reg, rc_reg, ca_reg, cb_reg, cc_reg;
    logic             v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind0;
            ra_reg    <= CAP_W'(in_reg.own_level);
            ca_reg    <= cap_own;
            rb_reg    <= CAP_W'(in_reg.next_level);
            cb_reg    <= (kind0 == KIND_ENTRY) ? cap_own : cap_nxt;
            rc_reg    <= (kind0 == KIND_ENTRY) ? bnd_lvl : CAP_W'(in_reg.branch_level);
            cc_reg    <= (kind0 == KIND_ENTRY) ? cap_own : cap_br;
        end
    end

    // ------------------------------------------------------------------
    // Three flow lanes with the critical-level flags and peak flows
    // carried beside them. Critical means twice the level against capacity.
    // ------------------------------------------------------------------
    sb_t            sb_next;
    sb_t            sb_reg  [FLOW_LAT];
    logic           sbv_reg [FLOW_LAT];
    logic [Q_W-1:0] qa, qb, qc;

    assign sb_next.kind   = kind1_reg;
    assign sb_next.own_bc = {ra_reg, 1'b0} < {1'b0, ca_reg};
    assign sb_next.own_gt = {ra_reg, 1'b0} > {1'b0, ca_reg};
    assign sb_next.nxt_bc = {rb_reg, 1'b0} < {1'b0, cb_reg};
    assign sb_next.nxt_gt = {rb_reg, 1'b0} > {1'b0, cb_reg};
    assign sb_next.l3_bc  = {rc_reg, 1'b0} < {1'b0, cc_reg};
    assign sb_next.qmax_a = qmax_of(fs_reg, ca_reg);
    assign sb_next.qmax_b = qmax_of(fs_reg, cb_reg);
    assign sb_next.qmax_c = qmax_of(fs_reg, cc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FLOW_LAT; k++)
                sbv_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            sbv_reg[0] <= v1_reg;
            for (int k = 1; k < FLOW_LAT; k++)
                sbv_reg[k] <= sbv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_next;
            for (int k = 1; k < FLOW_LAT; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    tcf_flow u_flow_a (.clk(clk), .en(en), .fs(fs_reg), .r(ra_reg), .cap(ca_reg), .q(qa));
    tcf_flow u_flow_b (.clk(clk), .en(en), .fs(fs_reg), .r(rb_reg), .cap(cb_reg), .q(qb));
    tcf_flow u_flow_c (.clk(clk), .en(en), .fs(fs_reg), .r(rc_reg), .cap(cc_reg), .q(qc));

    // ------------------------------------------------------------------
    // Stage g1: demand, supply and the Godunov selections.
    // ------------------------------------------------------------------
    sb_t            sbl;
    logic [Q_W-1:0] d_own, s_nxt, s_br, g_main, g_self;
    logic [Q_W-1:0] fx1, self1;

    assign sbl    = sb_reg[FLOW_LAT-1];
    assign d_own  = sbl.own_bc ? qa : sbl.qmax_a;
    assign s_nxt  = sbl.nxt_bc ? sbl.qmax_b : qb;
    assign s_br   = sbl.l3_bc ? sbl.qmax_c : qc;
    // Godunov flux from the own cell into the next one.
    assign g_main = sbl.own_bc ? (sbl.nxt_bc ? qa : qmin(qa, qb))
                               : (sbl.nxt_gt ? qb : sbl.qmax_a);
    // Godunov flux from the fixed boundary into the own cell.
    assign g_self = sbl.l3_bc ? (sbl.own_bc ? qc : qmin(qc, qa))
                              : (sbl.own_gt ? qa : sbl.qmax_a);

    always_comb
    begin
        self1 = '0;
        unique case (sbl.kind)
            KIND_ENTRY:
            begin
                fx1   = g_main;
                self1 = g_self;
            end
            KIND_EXIT:     fx1 = qa;
            KIND_DIVERGE:  fx1 = d_own;
            KIND_ORDINARY: fx1 = qmin(d_own, s_nxt);
        endcase
    end

    kind_t          g1_kind_reg;
    logic [Q_W-1:0] g1_fx_reg, g1_self_reg, g1_s1_reg, g1_s2_reg;
    logic           g1_v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_kind_reg <= sbl.kind;
            g1_fx_reg   <= fx1;
            g1_self_reg <= self1;
            g1_s1_reg   <= s_nxt;
            g1_s2_reg   <= s_br;
        end
    end

    // ------------------------------------------------------------------
    // Stage g2: demand times each share, to bound the share quotients.
    // min(D, S/a) is D when S*65536 >= D*a, else floor(S*65536/a) < D.
    // ------------------------------------------------------------------
    kind_t                 g2_kind_reg;
    logic [Q_W-1:0]        g2_fx_reg, g2_self_reg, g2_s1_reg, g2_s2_reg;
    logic [Q_W+SHR_W-1:0]  g2_prod1_reg;
    logic [Q_W+REST_W-1:0] g2_prod2_reg;
    logic                  g2_v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g2_kind_reg  <= g1_kind_reg;
            g2_fx_reg    <= g1_fx_reg;
            g2_self_reg  <= g1_self_reg;
            g2_s1_reg    <= g1_s1_reg;
            g2_s2_reg    <= g1_s2_reg;
            g2_prod1_reg <= {{SHR_W{1'b0}}, g1_fx_reg} * {{Q_W{1'b0}}, share_reg};
            g2_prod2_reg <= {{REST_W{1'b0}}, g1_fx_reg} * {{Q_W{1'b0}}, rest};
        end
    end

    // Share dividers with their side information.
    logic [Q_W+SHR_W-1:0] x1, x2;
    logic [Q_W-1:0]       quo1, quo2;
    dsb_t                 dsb_next;
    dsb_t                 dsb_reg  [DIV_STAGES];
    logic                 dsbv_reg [DIV_STAGES];

    assign x1 = {g2_s1_reg, {SHR_W{1'b0}}};
    assign x2 = {g2_s2_reg, {SHR_W{1'b0}}};

    assign dsb_next.kind    = g2_kind_reg;
    assign dsb_next.fx      = g2_fx_reg;
    assign dsb_next.self_in = g2_self_reg;
    // A share of zero drops the first-branch bound altogether.
    assign dsb_next.big1    = (share_reg == '0) || (x1 >= g2_prod1_reg);
    assign dsb_next.big2    = {1'b0, x2} >= g2_prod2_reg;

    tcf_div u_div_first (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(x1)),
        .den (CAP_W'(share_reg)),
        .quo (quo1)
    );

    tcf_div u_div_branch (
        .clk (clk),
        .en  (en),
        .num (NUM_W'(x2)),
        .den (CAP_W'(rest)),
        .quo (quo2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsb_reg[0] <= dsb_next;
            for (int k = 1; k < DIV_STAGES; k++)
                dsb_reg[k] <= dsb_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage g3: final outflow.
    // ------------------------------------------------------------------
    dsb_t           dl;
    logic [Q_W-1:0] q1, q2, fx3;

    assign dl  = dsb_reg[DIV_STAGES-1];
    assign q1  = dl.big1 ? dl.fx : quo1;
    assign q2  = dl.big2 ? dl.fx : quo2;
    assign fx3 = (dl.kind == KIND_DIVERGE) ? qmin(q1, q2) : dl.fx;

    kind_t          g3_kind_reg;
    logic [Q_W-1:0] g3_fx_reg, g3_self_reg;
    logic           g3_v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g3_kind_reg <= dl.kind;
            g3_fx_reg   <= fx3;
            g3_self_reg <= dl.self_in;
        end
    end

    // Valid bits of g1 through g3 and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_v_reg  <= 1'b0;
            g2_v_reg  <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
                dsbv_reg[k] <= 1'b0;
            g3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            g1_v_reg    <= sbv_reg[FLOW_LAT-1];
            g2_v_reg    <= g1_v_reg;
            dsbv_reg[0] <= g2_v_reg;
            for (int k = 1; k < DIV_STAGES; k++)
                dsbv_reg[k] <= dsbv_reg[k-1];
            g3_v_reg    <= dsbv_reg[DIV_STAGES-1];
            out_v_reg   <= g3_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: the split of a diverge flow and the valid flags.
    // ------------------------------------------------------------------
    logic [Q_W+SHR_W-1:0]  split1;
    logic [Q_W+REST_W-1:0] split2;
    out_item_t             out_next;
    out_item_t             out_reg;

    assign split1 = {{SHR_W{1'b0}}, g3_fx_reg} * {{Q_W{1'b0}}, share_reg};
    assign split2 = {{REST_W{1'b0}}, g3_fx_reg} * {{Q_W{1'b0}}, rest};

    always_comb
    begin
        out_next          = '0;
        out_next.out_flux = FLUX_W'(g3_fx_reg);
        unique case (g3_kind_reg)
            KIND_ENTRY:
            begin
                out_next.self_inflow       = FLUX_W'(g3_self_reg);
                out_next.self_inflow_valid = 1'b1;
                out_next.next_inflow       = FLUX_W'(g3_fx_reg);
                out_next.next_inflow_valid = 1'b1;
            end
            KIND_EXIT:
            begin
                out_next.next_inflow_valid = 1'b0;
            end
            KIND_DIVERGE:
            begin
                out_next.next_inflow         = FLUX_W'(split1[SHR_W +: Q_W]);
                out_next.next_inflow_valid   = 1'b1;
                out_next.branch_inflow       = FLUX_W'(split2[SHR_W +: Q_W]);
                out_next.branch_inflow_valid = 1'b1;
            end
            KIND_ORDINARY:
            begin
                out_next.next_inflow       = FLUX_W'(g3_fx_reg);
                out_next.next_inflow_valid = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign result.valid = out_v_reg;
    assign result.data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted transaction always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> v0_reg)
        else $error("accepted transaction did not enter the pipeline");

    // Only an entry cell reports a boundary inflow, and it also feeds downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.self_inflow_valid |-> result.data.next_inflow_valid)
        else $error("boundary inflow without a downstream inflow");

    // A boundary inflow that is not valid for the cell kind is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.self_inflow_valid |-> result.data.self_inflow == '0)
        else $error("unused boundary inflow is not zero");

    // A diverge split never hands out more than the cell's outflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.branch_inflow_valid
        |-> ({1'b0, result.data.next_inflow} + {1'b0, result.data.branch_inflow})
            <= {1'b0, result.data.out_flux})
        else $error("diverge split exceeds the outflow");

    // Without a stall at the output the pipeline keeps the next input open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> item.ready)
        else $error("input stalled while the output register is empty");

endmodule

### rtl/tcf_div.sv
// ============================================================================
// tcf_div: pipelined restoring divider
// Produces a Q_W-bit quotient, DIV_STEP bits per stage, one new
// division per enabled cycle. The upper part of the dividend must be
// below the divisor; otherwise the quotient is meaningless.
// ============================================================================
module tcf_div import tcf_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [CAP_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    typedef struct packed {
        logic [CAP_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   quo;
    } div_st_t;

    function automatic div_st_t div_stage(input div_st_t s, input logic [CAP_W-1:0] d);
        logic [CAP_W:0] t;
        div_st_t        r;
        r = s;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            t     = {r.rem, r.low[Q_W-1]};
            r.low = {r.low[Q_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                r.rem = CAP_W'(t - {1'b0, d});
                r.quo = {r.quo[Q_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = t[CAP_W-1:0];
                r.quo = {r.quo[Q_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    div_st_t          st_reg  [DIV_STAGES];
    logic [CAP_W-1:0] den_reg [DIV_STAGES];
    div_st_t          st_init;

    assign st_init.rem = num[NUM_W-1:Q_W];
    assign st_init.low = num[Q_W-1:0];
    assign st_init.quo = '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]  <= div_stage(st_init, den);
            den_reg[0] <= den;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                st_reg[k]  <= div_stage(st_reg[k-1], den_reg[k-1]);
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = st_reg[DIV_STAGES-1].quo;

endmodule

### rtl/tcf_flow.sv
// ============================================================================
// tcf_flow: Greenshields flow lane
// Computes floor(speed * r * (cap - r) / (256 * cap)), or zero when the
// level reaches the capacity, through the product registers and a divider.
// ============================================================================
module tcf_flow import tcf_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [SPD_W-1:0] fs,
    input  logic [CAP_W-1:0] r,
    input  logic [CAP_W-1:0] cap,
    output logic [Q_W-1:0]   q
);

    localparam int M_W        = SPD_W + CAP_W;
    localparam int HALF_W     = M_W / 2;
    localparam int PP_W       = CAP_W + HALF_W;
    localparam int N_W        = CAP_W + M_W;
    localparam int FLOW_SHIFT = 8;

    logic [CAP_W-1:0] diff;
    logic [M_W-1:0]   m_next;

    logic [M_W-1:0]   m_reg;
    logic [CAP_W-1:0] r1_reg, c1_reg, c2_reg, c3_reg;
    logic             over1_reg, over2_reg, over3_reg;
    logic [PP_W-1:0]  lo_reg, hi_reg;
    logic [N_W-1:0]   n_full;
    logic [NUM_W-1:0] np_reg;
    logic             over_reg [DIV_STAGES];
    logic [Q_W-1:0]   quo;

    assign diff   = cap - r;
    assign m_next = {{CAP_W{1'b0}}, fs} * {{SPD_W{1'b0}}, diff};
    assign n_full = {hi_reg, {HALF_W{1'b0}}} + N_W'(lo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage one: speed times headroom.
            m_reg     <= m_next;
            r1_reg    <= r;
            c1_reg    <= cap;
            over1_reg <= (r >= cap);
            // Stage two: level times that product, in two halves.
            lo_reg    <= {{HALF_W{1'b0}}, r1_reg} * {{CAP_W{1'b0}}, m_reg[HALF_W-1:0]};
            hi_reg    <= {{HALF_W{1'b0}}, r1_reg} * {{CAP_W{1'b0}}, m_reg[M_W-1:HALF_W]};
            c2_reg    <= c1_reg;
            over2_reg <= over1_reg;
            // Stage three: join the halves and drop the Q8 fraction.
            np_reg    <= n_full[NUM_W+FLOW_SHIFT-1:FLOW_SHIFT];
            c3_reg    <= c2_reg;
            over3_reg <= over2_reg;
            over_reg[0] <= over3_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                over_reg[k] <= over_reg[k-1];
            end
        end
    end

    tcf_div u_div (
        .clk (clk),
        .en  (en),
        .num (np_reg),
        .den (c3_reg),
        .quo (quo)
    );

    assign q = over_reg[DIV_STAGES-1] ? '0 : quo;

endmodule

### sim/tb_traffic_cell_flux.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_traffic_cell_flux: self-checking testbench of the traffic cell flux block
// Drives road cells through the valid/ready input channel, predicts each
// result from a local flux model and compares every result transaction.
// ============================================================================

module tb_traffic_cell_flux import tcf_pkg::*; ;

    // Scoreboard: holds the current register settings and the queue of
    // predicted results, and checks result transactions against it.
    class flux_scoreboard;
        logic [63:0] speed;
        logic [63:0] jam;
        logic [63:0] share;
        logic [63:0] bound;
        out_item_t   pending[$];
        int          errors;

        function new();
            speed  = 64'(FREE_SPEED_RST);
            jam    = 64'(JAM_LEVEL_RST);
            share  = 64'(SHARE_RST);
            bound  = 64'(BOUNDARY_RST);
            errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_FREE_SPEED:     speed = 64'(v[SPD_W-1:0]);
                REG_JAM_LEVEL:      jam   = 64'(v[JAM_W-1:0]);
                REG_DIVERGE_SHARE:  share = 64'(v[SHR_W-1:0]);
                REG_BOUNDARY_LEVEL: bound = 64'(v[LVL_W-1:0]);
                default: ;
            endcase
        endfunction

        function logic [63:0] capacity(logic [63:0] n);
            logic [63:0] nn, jj;
            nn = (n == 0) ? 64'd1 : n;
            jj = (jam == 0) ? 64'd1 : jam;
            return nn * jj;
        endfunction

        function logic [63:0] flow(logic [63:0] r, logic [63:0] c);
            if (r >= c)
                return 64'd0;
            return (speed * r * (c - r)) / (c * 64'd256);
        endfunction

        function logic [63:0] qmax(logic [63:0] c);
            return (speed * c) / 64'd1024;
        endfunction

        function bit is_free(logic [63:0] r, logic [63:0] c);
            return 64'd2 * r < c;
        endfunction

        function logic [63:0] lesser(logic [63:0] a, logic [63:0] b);
            return (a < b) ? a : b;
        endfunction

        function logic [63:0] demand(logic [63:0] r, logic [63:0] c);
            return is_free(r, c) ? flow(r, c) : qmax(c);
        endfunction

        function logic [63:0] supply(logic [63:0] r, logic [63:0] c);
            return is_free(r, c) ? qmax(c) : flow(r, c);
        endfunction

        function logic [63:0] godunov(logic [63:0] r1, logic [63:0] r2, logic [63:0] c);
            if (is_free(r1, c))
                return is_free(r2, c) ? flow(r1, c) : lesser(flow(r1, c), flow(r2, c));
            if (64'd2 * r2 > c)
                return flow(r2, c);
            return qmax(c);
        endfunction

        function logic [31:0] sat(logic [63:0] v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        // Works out the result of one accepted cell and queues it.
        function void note_cell(in_item_t it);
            logic [63:0] c, nc, bc, n, fl, si, ni, bi, rest;
            logic [63:0] own, nxt, br;
            out_item_t   e;
            n    = (it.lanes == 0) ? 64'd1 : 64'(it.lanes);
            own  = 64'(it.own_level);
            nxt  = 64'(it.next_level);
            br   = 64'(it.branch_level);
            c    = capacity(64'(it.lanes));
            nc   = capacity(64'(it.next_lanes));
            bc   = capacity(64'(it.branch_lanes));
            fl   = 0; si = 0; ni = 0; bi = 0;
            rest = 64'd65536 - share;
            e    = '0;
            case (kind_t'(it.cell_kind))
                KIND_ENTRY:
                begin
                    fl = godunov(own, nxt, c);
                    ni = fl;
                    si = godunov(bound * n, own, c);
                    e.self_inflow_valid = 1'b1;
                    e.next_inflow_valid = 1'b1;
                end
                KIND_EXIT:
                    fl = flow(own, c);
                KIND_DIVERGE:
                begin
                    fl = demand(own, c);
                    if (share != 0)
                        fl = lesser(fl, (supply(nxt, nc) << 16) / share);
                    fl = lesser(fl, (supply(br, bc) << 16) / rest);
                    ni = (fl * share) >> 16;
                    bi = (fl * rest) >> 16;
                    e.next_inflow_valid   = 1'b1;
                    e.branch_inflow_valid = 1'b1;
                end
                default:
                begin
                    fl = lesser(demand(own, c), supply(nxt, nc));
                    ni = fl;
                    e.next_inflow_valid = 1'b1;
                end
            endcase
            e.out_flux      = sat(fl);
            e.self_inflow   = sat(si);
            e.next_inflow   = sat(ni);
            e.branch_inflow = sat(bi);
            pending.push_back(e);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.out_flux !== e.out_flux)
            begin
                $display("%0t: out_flux exp %h got %h", $time, e.out_flux, got.out_flux);
                errors++;
            end
            if (got.self_inflow !== e.self_inflow)
            begin
                $display("%0t: self_inflow exp %h got %h", $time, e.self_inflow,
                         got.self_inflow);
                errors++;
            end
            if (got.self_inflow_valid !== e.self_inflow_valid)
            begin
                $display("%0t: self_inflow_valid exp %b got %b", $time,
                         e.self_inflow_valid, got.self_inflow_valid);
                errors++;
            end
            if (got.next_inflow !== e.next_inflow)
            begin
                $display("%0t: next_inflow exp %h got %h", $time, e.next_inflow,
                         got.next_inflow);
                errors++;
            end
            if (got.next_inflow_valid !== e.next_inflow_valid)
            begin
                $display("%0t: next_inflow_valid exp %b got %b", $time,
                         e.next_inflow_valid, got.next_inflow_valid);
                errors++;
            end
            if (got.branch_inflow !== e.branch_inflow)
            begin
                $display("%0t: branch_inflow exp %h got %h", $time, e.branch_inflow,
                         got.branch_inflow);
                errors++;
            end
            if (got.branch_inflow_valid !== e.branch_inflow_valid)
            begin
                $display("%0t: branch_inflow_valid exp %b got %b", $time,
                         e.branch_inflow_valid, got.branch_inflow_valid);
                errors++;
            end
        endfunction
    endclass

    // Settle time is a comfortable margin above the depth of the result pipeline.
    localparam int SETTLE      = 60;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    tcf_in_if  cell_ch ();
    tcf_out_if flux_ch ();

    traffic_cell_flux u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (cell_ch.sink),
        .result   (flux_ch.source)
    );

    flux_scoreboard board;
    int             cycles;
    bit             stall_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Every input is known from time zero; the scoreboard is built here too,
    // so that the monitors below never see a null handle.
    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_FREE_SPEED;
        wr_data       = '0;
        cell_ch.valid = 1'b0;
        cell_ch.data  = '0;
        flux_ch.ready = 1'b0;
        stall_on      = 1'b1;
    end

    // Cycle counter acting as the watchdog for the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end
    initial cycles = 0;

    // Monitors sample at the rising edge: an accepted cell transaction is
    // predicted, an accepted result transaction is checked.
    always @(posedge clk)
    begin
        if (rst_n && cell_ch.valid && cell_ch.ready)
            board.note_cell(cell_ch.data);
        if (rst_n && flux_ch.valid && flux_ch.ready)
            board.check_result(flux_ch.data);
    end

    // The receiver stalls on its own pattern: runs of random length, each
    // either steadily ready or under random back-pressure of varying density.
    initial
    begin
        int run, dens;
        @(posedge rst_n);
        forever
        begin
            run  = $urandom_range(5, 80);
            dens = $urandom_range(0, 3);
            repeat (run)
            begin
                @(negedge clk);
                if (!stall_on || dens == 0)
                    flux_ch.ready <= 1'b1;
                else
                    flux_ch.ready <= ($urandom_range(0, 3) >= dens);
            end
        end
    end

    // A register write pulses wr_en and tells the scoreboard; it is only issued while idle.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
        @(negedge clk);
        wr_en    <= 1'b0;
        board.set_reg(idx, v);
    endtask

    // Presents one cell and holds it until the transaction completes. Valid
    // stays high into the next cell when no gap follows.
    task automatic send_cell(in_item_t it, bit keep);
        cell_ch.valid <= 1'b1;
        cell_ch.data  <= it;
        do
            @(posedge clk);
        while (!cell_ch.ready);
        @(negedge clk);
        if (!keep)
            cell_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [LVL_W-1:0] rand_level(int unsigned cap);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return LVL_W'($urandom());
        if (pick == 1)
            return $urandom_range(0, 1) ? '1 : '0;
        if (cap == 0 || cap > 24'hFFFFF)
            return LVL_W'($urandom());
        // Around the cell's own critical and jam levels, or uniform up to its jam level.
        if (pick < 5)
            return LVL_W'((cap / 2) + $urandom_range(0, 8) - 4);
        if (pick == 5)
            return LVL_W'(cap + $urandom_range(0, 4) - 2);
        return LVL_W'($urandom_range(0, cap));
    endfunction

    function automatic in_item_t rand_cell(logic [63:0] jam_cfg);
        in_item_t it;
        it.cell_kind    = 2'($urandom_range(0, 3));
        it.lanes        = ($urandom_range(0, 15) == 0) ? LANE_W'($urandom())
                                                       : LANE_W'($urandom_range(1, 8));
        it.next_lanes   = ($urandom_range(0, 15) == 0) ? LANE_W'($urandom())
                                                       : LANE_W'($urandom_range(1, 8));
        it.branch_lanes = ($urandom_range(0, 15) == 0) ? LANE_W'($urandom())
                                                       : LANE_W'($urandom_range(1, 8));
        it.own_level    = rand_level(32'(64'(it.lanes) * jam_cfg));
        it.next_level   = rand_level(32'(64'(it.next_lanes) * jam_cfg));
        it.branch_level = rand_level(32'(64'(it.branch_lanes) * jam_cfg));
        return it;
    endfunction

    // Random cells in bursts with random gaps between them. Valid stays high
    // across a zero gap and drops after the last cell of the phase.
    task automatic random_phase(int count);
        int       left, burst, gap;
        in_item_t it;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            gap = $urandom_range(0, 6);
            for (int i = 0; i < burst; i++)
            begin
                it = rand_cell(board.jam);
                send_cell(it, (i != burst - 1) || (gap == 0 && left > burst));
            end
            left -= burst;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic directed_phase();
        in_item_t it;
        // Every kind at an empty, two partly filled and a full-scale own level, with
        // the zero-lane case folded into the last pass.
        for (int k = 0; k < 4; k++)
        begin
            for (int v = 0; v < 5; v++)
            begin
                it.cell_kind    = 2'(k);
                it.lanes        = (v == 4) ? 4'd0 : LANE_W'(2 + v);
                it.next_lanes   = (v == 4) ? 4'hF : 4'd1;
                it.branch_lanes = 4'd8;
                it.own_level    = (v == 0) ? '0 : (v == 1) ? 20'd38400 :
                                  (v == 2) ? 20'd115200 : '1;
                it.next_level   = (v == 1) ? '1 : LVL_W'(19200 * v);
                it.branch_level = (v == 3) ? '0 : '1;
                send_cell(it, !(k == 3 && v == 4));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_phase();
        drain();

        // Extreme settings: zero share drops the first supply term, zero jam level, top speed and
        // a boundary above jam, then the smallest nonzero speed, share and boundary with the largest jam level.
        write_reg(REG_DIVERGE_SHARE, '0);
        write_reg(REG_BOUNDARY_LEVEL, 20'd30000);
        random_phase(150);
        drain();
        write_reg(REG_FREE_SPEED, 20'hFFFF);
        write_reg(REG_JAM_LEVEL, '0);
        write_reg(REG_DIVERGE_SHARE, 20'hFFFF);
        write_reg(REG_BOUNDARY_LEVEL, '1);
        random_phase(150);
        drain();
        write_reg(REG_FREE_SPEED, 20'd1);
        write_reg(REG_JAM_LEVEL, 20'hFFFFF);
        write_reg(REG_DIVERGE_SHARE, 20'd1);
        write_reg(REG_BOUNDARY_LEVEL, 20'd1);
        random_phase(150);
        drain();

        // One stretch with the receiver always ready.
        stall_on = 1'b0;
        write_reg(REG_FREE_SPEED, 20'd8533);
        write_reg(REG_JAM_LEVEL, 20'd38400);
        write_reg(REG_DIVERGE_SHARE, 20'd32768);
        write_reg(REG_BOUNDARY_LEVEL, 20'd12000);
        random_phase(200);
        drain();
        stall_on = 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_FREE_SPEED, CFG_W'($urandom_range(1, 16'hFFFF)));
            write_reg(REG_JAM_LEVEL, CFG_W'($urandom_range(1, 20'h1FFFF)));
            write_reg(REG_DIVERGE_SHARE, CFG_W'($urandom()));
            write_reg(REG_BOUNDARY_LEVEL, CFG_W'($urandom_range(0, 20'h1FFFF)));
            random_phase(200);
            drain();
        end

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
